FILE: rtl/wss_pkg.sv
// Shared types and constants for the wildcard signature scanner.
`timescale 1ns / 1ps

package wss_pkg;

  localparam int unsigned CFG_DATA_BITS       = 64;
  localparam int unsigned CFG_INDEX_BITS      = 3;
  localparam int unsigned LENGTH_BITS         = 5;
  localparam int unsigned RANGE_BITS          = 24;
  localparam int unsigned OFFSET_BITS         = 24;
  localparam int unsigned PATTERN_STORE_BYTES = 16;
  localparam int unsigned PATTERN_SEL_BITS    = 4;

  localparam logic [7:0] WILDCARD_BYTE = 8'h3F;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_PATTERN_LOW    = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_PATTERN_HIGH   = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_PATTERN_LENGTH = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SCAN_RANGE     = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MATCH_OFFSET   = 3'd4;

  typedef struct packed {
    logic       active;
    logic [7:0] pat_byte;
  } wss_tap_t;

endpackage

FILE: rtl/wss_cell.sv
// One window cell: holds a byte, passes it on, and compares its pattern byte.
`timescale 1ns / 1ps

module wss_cell
  import wss_pkg::*;
(
  input  logic       clk,
  input  logic       advance,
  input  logic [7:0] byte_in,
  input  wss_tap_t   tap,
  output logic [7:0] byte_q,
  output logic       match
);

  always_ff @(posedge clk) begin
    if (advance) begin
      byte_q <= byte_in;
    end
  end

  assign match = !tap.active || (tap.pat_byte == WILDCARD_BYTE) || (tap.pat_byte == byte_in);

endmodule

FILE: rtl/wildcard_signature_scan.sv
// Top level of the wildcard signature scanner: config, cell chain, position and result.
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid/in_ready) takes one byte per transfer with first_byte and
//   last_byte flags. first_byte starts a new scan at index 0. Output channel
//   (out_valid/out_ready) returns at most one result per scan: found = 1 with the
//   match start index plus match_offset, or found = 0 when the byte flagged last
//   arrives with no match. After a result, bytes are dropped until first_byte.
//   Configuration writes (cfg_we/cfg_index/cfg_wdata) take effect at once; write
//   only while the scanner is idle.
//   Throughput: one byte per cycle unless stalled. Every cell compares its byte in
//   parallel as the window shifts, so the whole signature is checked in the cycle a
//   byte arrives. The result is registered into the output register on the clock
//   edge that transfers the byte that causes it.
//   Stall: while a result waits in the output register and out_ready is low,
//   in_ready is low; otherwise in_ready is high, so a result and a new byte can
//   transfer in the same cycle.
//   Reset: clears the configuration registers, position, scan status and out_valid.

module wildcard_signature_scan
  import wss_pkg::*;
#(
  parameter int unsigned MAX_PATTERN_BYTES = 16,
  parameter int unsigned POSITION_BITS     = 24
)(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [CFG_DATA_BITS-1:0]      cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    data_byte,
  input  logic                          first_byte,
  input  logic                          last_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          found,
  output logic signed [POSITION_BITS+1:0] match_value
);

  localparam int unsigned CELLS      = (MAX_PATTERN_BYTES < PATTERN_STORE_BYTES) ?
                                       MAX_PATTERN_BYTES : PATTERN_STORE_BYTES;
  localparam int unsigned COUNT_BITS = POSITION_BITS + 1;
  localparam int unsigned VALUE_BITS = POSITION_BITS + 2;
  localparam int unsigned CMP_BITS   = (COUNT_BITS > RANGE_BITS) ? COUNT_BITS : RANGE_BITS;
  localparam int unsigned SUM_BITS   = (VALUE_BITS > OFFSET_BITS) ? VALUE_BITS : OFFSET_BITS;

  logic [CFG_DATA_BITS-1:0] pattern_low;
  logic [CFG_DATA_BITS-1:0] pattern_high;
  logic [LENGTH_BITS-1:0]   pattern_length;
  logic [RANGE_BITS-1:0]    scan_range;
  logic signed [OFFSET_BITS-1:0] match_offset;

  logic [COUNT_BITS-1:0] position;
  logic                  scan_finished;

  logic [2*CFG_DATA_BITS-1:0] pattern_all;
  logic [LENGTH_BITS-1:0]     len_used;
  logic                       advance;
  logic [COUNT_BITS-1:0]      pos_cur;
  logic [COUNT_BITS-1:0]      pos_next;
  logic [COUNT_BITS-1:0]      start;
  logic                       hit;
  logic                       emit;
  logic                       all_match;
  logic signed [SUM_BITS-1:0] sum;

  logic [7:0]       chain_in [CELLS];
  logic [7:0]       chain_q  [CELLS];
  logic [CELLS-1:0] cell_match;
  wss_tap_t         taps     [CELLS];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      pattern_length <= '0;
      scan_range     <= '0;
      match_offset   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PATTERN_LOW:    pattern_low    <= cfg_wdata;
        CFG_PATTERN_HIGH:   pattern_high   <= cfg_wdata;
        CFG_PATTERN_LENGTH: pattern_length <= cfg_wdata[LENGTH_BITS-1:0];
        CFG_SCAN_RANGE:     scan_range     <= cfg_wdata[RANGE_BITS-1:0];
        CFG_MATCH_OFFSET:   match_offset   <= cfg_wdata[OFFSET_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign pattern_all = {pattern_high, pattern_low};
  assign len_used    = (pattern_length > LENGTH_BITS'(CELLS)) ? LENGTH_BITS'(CELLS)
                                                               : pattern_length;

  assign in_ready = !out_valid || out_ready;
  assign advance  = in_valid && in_ready && (first_byte || !scan_finished);

  // window chain
  for (genvar j = 0; j < CELLS; j++) begin : g_cell
    logic [LENGTH_BITS-1:0]      sel_full;
    logic [PATTERN_SEL_BITS-1:0] sel;

    assign sel_full = len_used - LENGTH_BITS'(1) - LENGTH_BITS'(j);
    assign sel      = sel_full[PATTERN_SEL_BITS-1:0];

    assign taps[j].active   = LENGTH_BITS'(j) < len_used;
    assign taps[j].pat_byte = pattern_all[8*sel +: 8];

    if (j == 0) begin : g_head
      assign chain_in[j] = data_byte;
    end else begin : g_body
      assign chain_in[j] = chain_q[j-1];
    end

    wss_cell u_cell (
      .clk     (clk),
      .advance (advance),
      .byte_in (chain_in[j]),
      .tap     (taps[j]),
      .byte_q  (chain_q[j]),
      .match   (cell_match[j])
    );
  end

  assign all_match = &cell_match;

  always_comb begin
    pos_cur  = first_byte ? '0 : position;
    pos_next = (&pos_cur) ? pos_cur : pos_cur + COUNT_BITS'(1);
    if (len_used == '0) begin
      start = '0;
      hit   = (pos_next == COUNT_BITS'(1)) && (scan_range != '0);
    end else begin
      start = pos_next - COUNT_BITS'(len_used);
      hit   = (pos_next >= COUNT_BITS'(len_used)) &&
              (CMP_BITS'(start) < CMP_BITS'(scan_range)) && all_match;
    end
    emit = advance && (hit || last_byte);
    sum  = $signed(SUM_BITS'(start)) + SUM_BITS'(match_offset);
  end

  // scan state
  always_ff @(posedge clk) begin
    if (rst) begin
      position      <= '0;
      scan_finished <= 1'b0;
    end else if (advance) begin
      position      <= pos_next;
      scan_finished <= emit;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      found       <= hit;
      match_value <= hit ? sum[VALUE_BITS-1:0] : '0;
    end
  end

endmodule
